// ===== sv/kpgd_pkg.sv =====
`timescale 1ns / 1ps

package kpgd_pkg;

	localparam int TIME_BITS_DEF = 48;

	localparam int CFG_DATA_BITS = 16;
	localparam int CFG_INDEX_BITS = 2;

	localparam logic [CFG_INDEX_BITS-1:0] REG_LONG_PRESS_TIME = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DOUBLE_PRESS_WINDOW = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DOUBLE_PRESS_ENABLE = 2'd2;

	localparam logic [15:0] LONG_PRESS_TIME_RST = 16'd500;
	localparam logic [15:0] DOUBLE_PRESS_WINDOW_RST = 16'd300;
	localparam logic DOUBLE_PRESS_ENABLE_RST = 1'b1;

	localparam logic [1:0] KIND_SINGLE = 2'd0;
	localparam logic [1:0] KIND_DOUBLE = 2'd1;
	localparam logic [1:0] KIND_LONG = 2'd2;

	localparam logic [1:0] KEY_RELEASE = 2'd0;
	localparam logic [1:0] KEY_PRESS = 2'd1;

	localparam logic OP_EVENT = 1'b1;

	typedef struct packed {
		logic [15:0] long_press_time;
		logic [15:0] double_press_window;
		logic        double_press_enable;
	} cfg_t;

endpackage

// ===== sv/kpgd_core.sv =====
`timescale 1ns / 1ps

module kpgd_core import kpgd_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  cfg_t                 cfg,
	input  logic                 op,
	input  logic [1:0]           key_value,
	input  logic [TIME_BITS-1:0] now_time,
	output logic                 gesture_valid,
	output logic [1:0]           gesture_kind,
	output logic                 deadline_valid,
	output logic [TIME_BITS:0]   next_deadline
);

	logic                 key_held_q;
	logic                 long_reported_q;
	logic                 single_pending_q;
	logic                 second_press_q;
	logic [TIME_BITS-1:0] press_time_q;
	logic [TIME_BITS:0]   single_deadline_q;

	logic                 key_held_d;
	logic                 long_reported_d;
	logic                 single_pending_d;
	logic                 second_press_d;
	logic [TIME_BITS-1:0] press_time_d;
	logic [TIME_BITS:0]   single_deadline_d;

	logic [TIME_BITS:0] now_wide;
	logic [TIME_BITS:0] long_deadline;
	logic [TIME_BITS:0] next_long_deadline;
	logic               fire_long;
	logic               fire_single;
	logic               pending_after_long;
	logic               do_press;
	logic               do_release;

	assign now_wide = {1'b0, now_time};
	assign long_deadline = {1'b0, press_time_q} + {{(TIME_BITS-15){1'b0}}, cfg.long_press_time};
	assign next_long_deadline = {1'b0, press_time_d}
		+ {{(TIME_BITS-15){1'b0}}, cfg.long_press_time};

	assign fire_long = key_held_q && !long_reported_q && (now_wide >= long_deadline);
	assign pending_after_long = single_pending_q && !fire_long;
	assign fire_single = !key_held_q && pending_after_long && (now_wide >= single_deadline_q);
	assign do_press = (op == OP_EVENT) && (key_value == KEY_PRESS) && !key_held_q;
	assign do_release = (op == OP_EVENT) && (key_value == KEY_RELEASE) && key_held_q;

	always_comb begin
		key_held_d = key_held_q;
		long_reported_d = long_reported_q || fire_long;
		single_pending_d = pending_after_long && !fire_single;
		second_press_d = second_press_q;
		press_time_d = press_time_q;
		single_deadline_d = single_deadline_q;
		gesture_valid = fire_long || fire_single;
		gesture_kind = fire_long ? KIND_LONG : KIND_SINGLE;

		if (do_press) begin
			second_press_d = single_pending_d;
			single_pending_d = 1'b0;
			key_held_d = 1'b1;
			long_reported_d = 1'b0;
			press_time_d = now_time;
		end else if (do_release) begin
			key_held_d = 1'b0;
			if (!long_reported_d) begin
				if (second_press_q) begin
					second_press_d = 1'b0;
					gesture_valid = 1'b1;
					gesture_kind = KIND_DOUBLE;
				end else if (cfg.double_press_enable) begin
					single_pending_d = 1'b1;
					single_deadline_d = now_wide
						+ {{(TIME_BITS-15){1'b0}}, cfg.double_press_window};
				end else begin
					gesture_valid = 1'b1;
					gesture_kind = KIND_SINGLE;
				end
			end
		end
	end

	always_comb begin
		if (key_held_d && !long_reported_d) begin
			deadline_valid = 1'b1;
			next_deadline = next_long_deadline;
		end else if (single_pending_d) begin
			deadline_valid = 1'b1;
			next_deadline = single_deadline_d;
		end else begin
			deadline_valid = 1'b0;
			next_deadline = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_held_q <= 1'b0;
			long_reported_q <= 1'b0;
			single_pending_q <= 1'b0;
			second_press_q <= 1'b0;
			press_time_q <= '0;
			single_deadline_q <= '0;
		end else if (step) begin
			key_held_q <= key_held_d;
			long_reported_q <= long_reported_d;
			single_pending_q <= single_pending_d;
			second_press_q <= second_press_d;
			press_time_q <= press_time_d;
			single_deadline_q <= single_deadline_d;
		end
	end

endmodule

// ===== sv/key_press_gesture_detector.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// s_axis    in         s_tvalid/s_tready  tuser: op; tdata: key_value, now_time
// m_axis    out        m_tvalid/m_tready  tuser: gesture_valid, deadline_valid;
//                                         tdata: gesture_kind, next_deadline
// cfg       in         cfg_we             cfg_index, cfg_wdata
//
// One item per cycle is sustained while m_tready is high. An accepted transfer is
// captured in the input register, classified against the key state, and lands in
// the result register. Reset clears the key state and loads the register defaults.
// A stalled result holds the input stage; the input side keeps taking transfers
// whenever the result register is empty or is being drained.

module key_press_gesture_detector import kpgd_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF,
	localparam int IN_BITS = ((2 + TIME_BITS + 7) / 8) * 8,
	localparam int OUT_BITS = ((3 + TIME_BITS + 7) / 8) * 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [IN_BITS-1:0]        s_tdata,  // key_value, now_time
	input  logic                      s_tuser,  // op
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [OUT_BITS-1:0]       m_tdata,  // gesture_kind, next_deadline
	output logic [1:0]                m_tuser,  // gesture_valid, deadline_valid
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

	cfg_t cfg_q;

	logic                 valid_s1;
	logic                 op_s1;
	logic [1:0]           key_s1;
	logic [TIME_BITS-1:0] now_s1;

	logic                 valid_s2;
	logic                 gesture_valid_s2;
	logic [1:0]           gesture_kind_s2;
	logic                 deadline_valid_s2;
	logic [TIME_BITS:0]   next_deadline_s2;

	logic                 advance;
	logic                 gesture_valid;
	logic [1:0]           gesture_kind;
	logic                 deadline_valid;
	logic [TIME_BITS:0]   next_deadline;

	assign advance = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press_time <= LONG_PRESS_TIME_RST;
			cfg_q.double_press_window <= DOUBLE_PRESS_WINDOW_RST;
			cfg_q.double_press_enable <= DOUBLE_PRESS_ENABLE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LONG_PRESS_TIME: cfg_q.long_press_time <= cfg_wdata;
				REG_DOUBLE_PRESS_WINDOW: cfg_q.double_press_window <= cfg_wdata;
				REG_DOUBLE_PRESS_ENABLE: cfg_q.double_press_enable <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1 <= s_tuser;
			key_s1 <= s_tdata[1:0];
			now_s1 <= s_tdata[TIME_BITS+1:2];
		end
	end

	kpgd_core #(
		.TIME_BITS(TIME_BITS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.cfg           (cfg_q),
		.op            (op_s1),
		.key_value     (key_s1),
		.now_time      (now_s1),
		.gesture_valid (gesture_valid),
		.gesture_kind  (gesture_kind),
		.deadline_valid(deadline_valid),
		.next_deadline (next_deadline)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			gesture_valid_s2 <= gesture_valid;
			gesture_kind_s2 <= gesture_valid ? gesture_kind : KIND_SINGLE;
			deadline_valid_s2 <= deadline_valid;
			next_deadline_s2 <= next_deadline;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser = {deadline_valid_s2, gesture_valid_s2};
	assign m_tdata = {{(OUT_BITS-TIME_BITS-3){1'b0}}, next_deadline_s2, gesture_kind_s2};

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import kpgd_pkg::*;

	localparam int TB = TIME_BITS_DEF;
	localparam int IN_W = ((2 + TB + 7) / 8) * 8;
	localparam int OUT_W = ((3 + TB + 7) / 8) * 8;
	localparam int STALL_LIMIT = 3000;
	localparam logic OP_TICK = ~OP_EVENT;
	localparam logic [1:0] KEY_REPEAT = 2'd2;
	localparam logic [1:0] KEY_UNUSED = 2'd3;

	typedef struct packed {
		logic          gv;
		logic [1:0]    kind;
		logic          dv;
		logic [TB:0]   due;
	} gesture_t;

	class key_gesture_book;
		bit [15:0] hold_ms = LONG_PRESS_TIME_RST;
		bit [15:0] window_ms = DOUBLE_PRESS_WINDOW_RST;
		bit double_on = DOUBLE_PRESS_ENABLE_RST;
		bit held;
		bit long_done;
		bit single_wait;
		bit second;
		bit [TB-1:0] press_at;
		bit [TB:0] single_due;
		gesture_t owed[$];
		int mismatches;

		function void set_register(logic [CFG_INDEX_BITS-1:0] idx, bit [15:0] val);
			case (idx)
				REG_LONG_PRESS_TIME: hold_ms = val;
				REG_DOUBLE_PRESS_WINDOW: window_ms = val;
				REG_DOUBLE_PRESS_ENABLE: double_on = val[0];
				default: ;
			endcase
		endfunction

		function bit [TB:0] long_due();
			bit [TB:0] sum;
			sum = {1'b0, press_at} + hold_ms;
			return sum;
		endfunction

		function bit [TB:0] upcoming();
			if (held && !long_done)
				return long_due();
			if (single_wait)
				return single_due;
			return '0;
		endfunction

		function void take_key_item(bit op, bit [1:0] key, bit [TB-1:0] now);
			gesture_t g;
			g = '0;
			if (held && !long_done && {1'b0, now} >= long_due()) begin
				long_done = 1'b1;
				single_wait = 1'b0;
				g.gv = 1'b1;
				g.kind = KIND_LONG;
			end
			if (!held && single_wait && {1'b0, now} >= single_due) begin
				single_wait = 1'b0;
				g.gv = 1'b1;
				g.kind = KIND_SINGLE;
			end
			if (op == OP_EVENT) begin
				if (key == KEY_PRESS && !held) begin
					second = single_wait;
					single_wait = 1'b0;
					held = 1'b1;
					long_done = 1'b0;
					press_at = now;
				end else if (key == KEY_RELEASE && held) begin
					held = 1'b0;
					if (!long_done) begin
						if (second) begin
							second = 1'b0;
							g.gv = 1'b1;
							g.kind = KIND_DOUBLE;
						end else if (double_on) begin
							single_wait = 1'b1;
							single_due = {1'b0, now} + window_ms;
						end else begin
							g.gv = 1'b1;
							g.kind = KIND_SINGLE;
						end
					end
				end
			end
			g.dv = (held && !long_done) || single_wait;
			g.due = upcoming();
			owed.push_back(g);
		endfunction

		function void match_gesture(gesture_t got);
			gesture_t exp;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer: valid=%0b kind=%0d pending=%0b deadline=%0h",
						got.gv, got.kind, got.dv, got.due);
				return;
			end
			exp = owed.pop_front();
			if (got !== exp) begin
				mismatches++;
				if (mismatches <= 10)
					$display("gesture mismatch: expected valid=%0b kind=%0d pending=%0b deadline=%0h, %s",
						exp.gv, exp.kind, exp.dv, exp.due,
						$sformatf("got valid=%0b kind=%0d pending=%0b deadline=%0h",
							got.gv, got.kind, got.dv, got.due));
			end
		endfunction

		function bit clean();
			return mismatches == 0 && owed.size() == 0;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic [1:0] m_tuser;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

	key_gesture_book book;
	bit calm;
	bit [TB-1:0] stamp;
	int quiet_cycles;

	key_press_gesture_detector #(.TIME_BITS(TB)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		gesture_t got;
		if (arst_n) begin
			m_tready <= calm || $urandom_range(99) >= 16;
			if (m_tvalid && m_tready) begin
				got.gv = m_tuser[0];
				got.dv = m_tuser[1];
				got.kind = m_tdata[1:0];
				got.due = m_tdata[TB+2:2];
				book.match_gesture(got);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_item(input bit op, input bit [1:0] key, input bit [TB-1:0] now);
		while (!calm && $urandom_range(99) < 16) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= IN_W'({now, key});
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		book.take_key_item(op, key, now);
		stamp = now;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (book.owed.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input bit [15:0] hold, input bit [15:0] window, input bit dbl);
		cfg_we <= 1'b1;
		cfg_index <= REG_LONG_PRESS_TIME;
		cfg_wdata <= hold;
		@(posedge clk);
		cfg_index <= REG_DOUBLE_PRESS_WINDOW;
		cfg_wdata <= window;
		@(posedge clk);
		cfg_index <= REG_DOUBLE_PRESS_ENABLE;
		cfg_wdata <= CFG_DATA_BITS'(dbl);
		@(posedge clk);
		cfg_we <= 1'b0;
		book.set_register(REG_LONG_PRESS_TIME, hold);
		book.set_register(REG_DOUBLE_PRESS_WINDOW, window);
		book.set_register(REG_DOUBLE_PRESS_ENABLE, dbl);
	endtask

	function automatic bit [TB-1:0] next_stamp();
		bit [TB:0] due;
		bit [63:0] wide;
		int r;
		r = $urandom_range(99);
		due = book.upcoming();
		wide = {$urandom(), $urandom()};
		if (r < 2)
			return stamp - $urandom_range(50);
		if (r < 3)
			return wide[TB-1:0];
		if (r < 12 && due != '0 && !due[TB] && due[TB-1:0] >= stamp)
			return (r < 8) ? due[TB-1:0] : due[TB-1:0] - 1'b1;
		if (r < 30)
			return stamp;
		if (r < 60)
			return stamp + $urandom_range(book.hold_ms + 20);
		if (r < 90)
			return stamp + $urandom_range(book.window_ms + 20);
		return stamp + $urandom_range(200000);
	endfunction

	// Mostly press and release in turn with random timing around the
	// configured windows; the rest is ignored keys, ticks and odd events.
	task automatic random_run(input int count);
		bit [TB-1:0] now;
		bit op;
		bit [1:0] key;
		for (int n = 0; n < count; n++) begin
			now = next_stamp();
			if ($urandom_range(99) < 85) begin
				if (book.held) begin
					op = ($urandom_range(9) < 7) ? OP_EVENT : OP_TICK;
					key = KEY_RELEASE;
				end else begin
					op = $urandom_range(1) ? OP_EVENT : OP_TICK;
					key = KEY_PRESS;
				end
			end else begin
				op = $urandom_range(1) ? OP_EVENT : OP_TICK;
				key = 2'($urandom_range(3));
			end
			send_item(op, key, now);
		end
	endtask

	task automatic directed_run();
		bit [TB-1:0] top;
		top = '1;
		send_item(OP_TICK, KEY_PRESS, 0);
		send_item(OP_EVENT, KEY_RELEASE, 10);
		send_item(OP_EVENT, KEY_PRESS, 100);
		send_item(OP_EVENT, KEY_PRESS, 150);
		send_item(OP_EVENT, KEY_REPEAT, 200);
		send_item(OP_EVENT, KEY_UNUSED, 250);
		send_item(OP_TICK, KEY_RELEASE, 599);
		send_item(OP_TICK, KEY_RELEASE, 600);
		send_item(OP_EVENT, KEY_RELEASE, 700);
		send_item(OP_EVENT, KEY_PRESS, 1000);
		send_item(OP_EVENT, KEY_RELEASE, 1100);
		send_item(OP_TICK, KEY_RELEASE, 1399);
		send_item(OP_TICK, KEY_RELEASE, 1400);
		send_item(OP_EVENT, KEY_PRESS, 2000);
		send_item(OP_EVENT, KEY_RELEASE, 2100);
		send_item(OP_EVENT, KEY_PRESS, 2200);
		send_item(OP_EVENT, KEY_RELEASE, 2300);
		send_item(OP_EVENT, KEY_PRESS, top - 99);
		send_item(OP_EVENT, KEY_RELEASE, top);
		send_item(OP_TICK, KEY_RELEASE, 5);
		send_item(OP_TICK, KEY_UNUSED, top);
		send_item(OP_EVENT, KEY_PRESS, top);
		send_item(OP_EVENT, KEY_RELEASE, top);
	endtask

	initial begin
		book = new();
		calm = 1'b0;
		stamp = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_run();
		stamp = TB'(3000);
		random_run(250);

		settle();
		configure(16'd0, 16'd0, 1'b1);
		random_run(250);

		settle();
		configure(16'hFFFF, 16'hFFFF, 1'b1);
		calm = 1'b1;
		random_run(250);
		calm = 1'b0;

		settle();
		configure(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)), 1'b0);
		random_run(250);

		settle();
		configure(16'd40, 16'd25, 1'b0);
		stamp = '1;
		stamp = stamp - 200000;
		random_run(250);

		settle();
		configure(16'($urandom_range(2000)), 16'($urandom_range(2000)), 1'b1);
		random_run(250);

		settle();
		repeat (8) @(posedge clk);
		if (book.clean())
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
